FILE: rtl/core/bimm_pkg.sv
`default_nettype none
package bimm_pkg;

    localparam int DIM_W      = 7;
    localparam int IDX_W      = 6;
    localparam int ELEM_W     = 32;
    localparam int KIND_W     = 3;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_USER_W = KIND_W + 1;
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;

    localparam logic [KIND_W-1:0] REQ_WRITE_A = 3'd0;
    localparam logic [KIND_W-1:0] REQ_WRITE_B = 3'd1;
    localparam logic [KIND_W-1:0] REQ_WRITE_C = 3'd2;
    localparam logic [KIND_W-1:0] REQ_COMPUTE = 3'd3;
    localparam logic [KIND_W-1:0] REQ_READ_C  = 3'd4;

    localparam logic [1:0] REG_ROWS_A    = 2'd0;
    localparam logic [1:0] REG_INNER_DIM = 2'd1;
    localparam logic [1:0] REG_COLS_B    = 2'd2;

    typedef struct packed {
        logic valid;
        logic last;
    } mac_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/core/blocked_int_matrix_multiply_core.sv
// Element writes: accept, then result beat from ST_RESP;
// C read: accept, C memory read in ST_RD, then result beat from ST_RESP.
// Compute: per C element, inner_dim A/B memory reads (one per cycle) in ST_MAC,
// then pipeline drain in ST_DRAIN and C read-modify-write in ST_CWB.
// One request in flight.
// After reset the C memory is swept to zero, all MAX_DIM*MAX_DIM entries; no input taken.
`default_nettype none
module blocked_int_matrix_multiply_core #(
    parameter int MAX_DIM = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bimm_pkg::APB_AW-1:0]       paddr,
    input  logic [bimm_pkg::APB_DW-1:0]       pwdata,
    output logic [bimm_pkg::APB_DW-1:0]       prdata,
    output logic                              pready,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [5:0] row_index, [11:6] col_index, [43:12] elem_value, [47:44] zero
    input  logic [bimm_pkg::IN_DATA_W-1:0]    s_tdata,
    // [2:0] req_type
    input  logic [bimm_pkg::KIND_W-1:0]       s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] read_data
    output logic [bimm_pkg::ELEM_W-1:0]       m_tdata,
    // [2:0] req_echo, [3] index_error
    output logic [bimm_pkg::OUT_USER_W-1:0]   m_tuser
);
    import bimm_pkg::*;

    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int AW      = $clog2(DEPTH);
    localparam int DIM_RST = (64 > MAX_DIM) ? MAX_DIM : 64;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_RD, ST_MAC, ST_DRAIN, ST_CWB, ST_RESP
    } state_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        if (int'(v) > MAX_DIM)
            clamp_dim = DIM_W'(MAX_DIM);
        else
            clamp_dim = v;
    endfunction

    function automatic logic [AW-1:0] elem_addr(input logic [DIM_W-1:0] r,
                                                input logic [DIM_W-1:0] c);
        elem_addr = AW'(int'(r) * MAX_DIM + int'(c));
    endfunction

    // configuration
    logic [DIM_W-1:0] rows_a_reg, inner_dim_reg, cols_b_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= DIM_W'(DIM_RST);
            inner_dim_reg <= DIM_W'(DIM_RST);
            cols_b_reg    <= DIM_W'(DIM_RST);
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_ROWS_A:    rows_a_reg    <= clamp_dim(pwdata[DIM_W-1:0]);
                REG_INNER_DIM: inner_dim_reg <= clamp_dim(pwdata[DIM_W-1:0]);
                REG_COLS_B:    cols_b_reg    <= clamp_dim(pwdata[DIM_W-1:0]);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_ROWS_A:    prdata = APB_DW'(rows_a_reg);
            REG_INNER_DIM: prdata = APB_DW'(inner_dim_reg);
            REG_COLS_B:    prdata = APB_DW'(cols_b_reg);
            default:       prdata = '0;
        endcase
    end

    // input decode
    logic [KIND_W-1:0] in_kind;
    logic [DIM_W-1:0]  in_row, in_col;
    logic [ELEM_W-1:0] in_val;
    logic [AW-1:0]     in_addr;
    logic              in_err;
    logic              s_accept;

    assign in_kind = s_tuser;
    assign in_row  = DIM_W'(s_tdata[IDX_W-1:0]);
    assign in_col  = DIM_W'(s_tdata[2*IDX_W-1:IDX_W]);
    assign in_val  = s_tdata[2*IDX_W+ELEM_W-1:2*IDX_W];
    assign in_addr = elem_addr(in_row, in_col);

    always_comb
    begin
        case (in_kind)
            REQ_WRITE_A: in_err = !(in_row < rows_a_reg && in_col < inner_dim_reg);
            REQ_WRITE_B: in_err = !(in_row < inner_dim_reg && in_col < cols_b_reg);
            REQ_WRITE_C: in_err = !(in_row < rows_a_reg && in_col < cols_b_reg);
            REQ_READ_C:  in_err = !(in_row < rows_a_reg && in_col < cols_b_reg);
            default:     in_err = 1'b0;
        endcase
    end

    // state
    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [DIM_W-1:0]  i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic              d_v_reg, d_v_next, d_last_reg, d_last_next;
    logic [ELEM_W-1:0] total_reg, total_next;
    logic [KIND_W-1:0] pend_kind_reg, pend_kind_next;
    logic              pend_err_reg, pend_err_next;
    logic [ELEM_W-1:0] pend_data_reg, pend_data_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [ELEM_W-1:0] m_data_reg, m_data_next;
    logic [OUT_USER_W-1:0] m_user_reg, m_user_next;

    logic              c_we;
    logic [AW-1:0]     c_waddr;
    logic [ELEM_W-1:0] c_wdata;
    logic [ELEM_W-1:0] a_rdata, b_rdata, c_rdata;
    logic              a_we, b_we;
    logic [AW-1:0]     c_raddr;
    logic              mac_done;
    logic [ELEM_W-1:0] mac_sum;
    mac_ctl_t          mac_ctl;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid & s_tready;
    assign a_we     = s_accept && in_kind == REQ_WRITE_A && !in_err;
    assign b_we     = s_accept && in_kind == REQ_WRITE_B && !in_err;
    assign c_raddr  = (state_reg == ST_IDLE) ? in_addr : elem_addr(i_reg, j_reg);
    assign mac_ctl  = '{valid: d_v_reg, last: d_last_reg};

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        d_v_next       = 1'b0;
        d_last_next    = 1'b0;
        total_next     = total_reg;
        pend_kind_next = pend_kind_reg;
        pend_err_next  = pend_err_reg;
        pend_data_next = pend_data_reg;
        m_tvalid_next  = m_tvalid_reg & ~m_tready;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        c_we           = 1'b0;
        c_waddr        = elem_addr(i_reg, j_reg);
        c_wdata        = c_rdata + total_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                c_we     = 1'b1;
                c_waddr  = clr_reg;
                c_wdata  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    pend_kind_next = in_kind;
                    pend_err_next  = in_err;
                    pend_data_next = '0;
                    state_next     = ST_RESP;
                    case (in_kind)
                        REQ_WRITE_C:
                        begin
                            c_we    = !in_err;
                            c_waddr = in_addr;
                            c_wdata = in_val;
                        end
                        REQ_READ_C:
                        begin
                            if (!in_err)
                                state_next = ST_RD;
                        end
                        REQ_COMPUTE:
                        begin
                            if (rows_a_reg != '0 && inner_dim_reg != '0 && cols_b_reg != '0)
                            begin
                                i_next     = '0;
                                j_next     = '0;
                                k_next     = '0;
                                state_next = ST_MAC;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RD:
            begin
                pend_data_next = c_rdata;
                state_next     = ST_RESP;
            end
            ST_MAC:
            begin
                d_v_next = 1'b1;
                if (k_reg == inner_dim_reg - 1'b1)
                begin
                    d_last_next = 1'b1;
                    k_next      = '0;
                    state_next  = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // C(i,j) is being read this cycle, ready in ST_CWB
                if (mac_done)
                begin
                    total_next = mac_sum;
                    state_next = ST_CWB;
                end
            end
            ST_CWB:
            begin
                c_we       = 1'b1;
                state_next = ST_MAC;
                if (j_reg == cols_b_reg - 1'b1)
                begin
                    j_next = '0;
                    if (i_reg == rows_a_reg - 1'b1)
                        state_next = ST_RESP;
                    else
                        i_next = i_reg + 1'b1;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = pend_data_reg;
                    m_user_next   = {pend_err_reg, pend_kind_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            d_v_reg       <= 1'b0;
            d_last_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            total_reg     <= '0;
            pend_kind_reg <= '0;
            pend_err_reg  <= 1'b0;
            pend_data_reg <= '0;
            m_data_reg    <= '0;
            m_user_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            d_v_reg       <= d_v_next;
            d_last_reg    <= d_last_next;
            m_tvalid_reg  <= m_tvalid_next;
            total_reg     <= total_next;
            pend_kind_reg <= pend_kind_next;
            pend_err_reg  <= pend_err_next;
            pend_data_reg <= pend_data_next;
            m_data_reg    <= m_data_next;
            m_user_reg    <= m_user_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    bimm_ram #(.DEPTH(DEPTH), .AW(AW)) u_a_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (in_addr),
        .wdata (in_val),
        .raddr (elem_addr(i_reg, k_reg)),
        .rdata (a_rdata)
    );

    bimm_ram #(.DEPTH(DEPTH), .AW(AW)) u_b_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (in_addr),
        .wdata (in_val),
        .raddr (elem_addr(k_reg, j_reg)),
        .rdata (b_rdata)
    );

    bimm_ram #(.DEPTH(DEPTH), .AW(AW)) u_c_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    bimm_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .a_data (a_rdata),
        .b_data (b_rdata),
        .done   (mac_done),
        .sum    (mac_sum)
    );

    a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> state_reg == ST_DRAIN)
        else $error("dot product finished outside drain");

    a_read_path: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && in_kind == REQ_READ_C && !in_err) |=> state_reg == ST_RD)
        else $error("valid C read did not enter read state");

    a_c_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        c_we |-> (state_reg == ST_CLEAR || state_reg == ST_CWB || s_accept))
        else $error("stray C memory write");

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC || state_reg == ST_DRAIN || state_reg == ST_CLEAR) |-> !s_tready)
        else $error("input taken while busy");

endmodule
`default_nettype wire

FILE: rtl/core/bimm_ram.sv
`default_nettype none
module bimm_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [AW-1:0]                 waddr,
    input  logic [bimm_pkg::ELEM_W-1:0]   wdata,
    input  logic [AW-1:0]                 raddr,
    output logic [bimm_pkg::ELEM_W-1:0]   rdata
);
    import bimm_pkg::*;

    logic [ELEM_W-1:0] mem [DEPTH];
    logic [ELEM_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: rtl/core/bimm_mac.sv
`default_nettype none
module bimm_mac (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bimm_pkg::mac_ctl_t            ctl,
    input  logic [bimm_pkg::ELEM_W-1:0]   a_data,
    input  logic [bimm_pkg::ELEM_W-1:0]   b_data,
    output logic                          done,
    output logic [bimm_pkg::ELEM_W-1:0]   sum
);
    import bimm_pkg::*;

    logic [ELEM_W-1:0] prod_reg;
    logic [ELEM_W-1:0] acc_reg;
    logic              p_v_reg;
    logic              p_last_reg;

    // running dot product; wraps mod 2^32
    assign sum  = acc_reg + prod_reg;
    assign done = p_v_reg & p_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_v_reg    <= 1'b0;
            p_last_reg <= 1'b0;
            acc_reg    <= '0;
        end
        else
        begin
            p_v_reg    <= ctl.valid;
            p_last_reg <= ctl.last;
            if (p_v_reg)
            begin
                acc_reg <= p_last_reg ? '0 : sum;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.valid)
        begin
            prod_reg <= a_data * b_data;
        end
    end

endmodule
`default_nettype wire

FILE: tb/blocked_int_matrix_multiply_core_test.sv
`timescale 1ns / 100ps
`default_nettype none
module blocked_int_matrix_multiply_core_test;
    import bimm_pkg::*;

    localparam int MAX_DIM = 64;
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam logic [KIND_W-1:0] REQ_UNUSED_LO = REQ_READ_C + 3'd1;
    localparam int HOLD_CYCLES = 300;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [ELEM_W-1:0] val;
    } request_t;

    typedef struct {
        logic [ELEM_W-1:0] data;
        logic [KIND_W-1:0] kind;
        logic              err;
    } answer_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_AW-1:0]     paddr = '0;
    logic [APB_DW-1:0]     pwdata = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [KIND_W-1:0]     s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [ELEM_W-1:0]     m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    blocked_int_matrix_multiply_core #(.MAX_DIM(MAX_DIM)) DUT (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    request_t   pending_q[$];
    answer_t    answer_q[$];
    request_t   on_bus;
    logic       in_fire = 1'b0;
    idle_mode_t idle_mode = IDLE_NONE;
    logic       stall_go = 1'b0;
    logic       stall_taken = 1'b0;
    int         hold_cnt = 0;
    int         mismatches = 0;

    // predictor copy of the element stores and dimension registers
    logic [ELEM_W-1:0] a_mem[DEPTH];
    logic [ELEM_W-1:0] b_mem[DEPTH];
    logic [ELEM_W-1:0] c_mem[DEPTH];
    int                dim_rows = MAX_DIM;
    int                dim_inner = MAX_DIM;
    int                dim_cols = MAX_DIM;

    // generator side: entries that some queued write has filled
    bit a_filled[DEPTH];
    bit b_filled[DEPTH];

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            a_mem[i] = '0;
            b_mem[i] = '0;
            c_mem[i] = '0;
        end
    end

    function automatic answer_t predict_answer(request_t r);
        answer_t ans;
        int      ri;
        int      ci;
        logic [ELEM_W-1:0] acc;
        ri = int'(r.row);
        ci = int'(r.col);
        ans.data = '0;
        ans.kind = r.kind;
        ans.err = 1'b0;
        case (r.kind)
            REQ_WRITE_A:
                if (ri < dim_rows && ci < dim_inner) a_mem[ri*MAX_DIM+ci] = r.val;
                else ans.err = 1'b1;
            REQ_WRITE_B:
                if (ri < dim_inner && ci < dim_cols) b_mem[ri*MAX_DIM+ci] = r.val;
                else ans.err = 1'b1;
            REQ_WRITE_C:
                if (ri < dim_rows && ci < dim_cols) c_mem[ri*MAX_DIM+ci] = r.val;
                else ans.err = 1'b1;
            REQ_READ_C:
                if (ri < dim_rows && ci < dim_cols) ans.data = c_mem[ri*MAX_DIM+ci];
                else ans.err = 1'b1;
            REQ_COMPUTE:
                for (int i = 0; i < dim_rows; i++)
                    for (int j = 0; j < dim_cols; j++)
                    begin
                        acc = '0;
                        for (int k = 0; k < dim_inner; k++)
                            acc = acc + a_mem[i*MAX_DIM+k] * b_mem[k*MAX_DIM+j];
                        c_mem[i*MAX_DIM+j] = c_mem[i*MAX_DIM+j] + acc;
                    end
            default: ;
        endcase
        return ans;
    endfunction

    // input side: accepted beats feed the predictor
    always @(posedge clk)
    begin
        in_fire <= s_tvalid && s_tready;
        if (s_tvalid && s_tready)
            answer_q.push_back(predict_answer(on_bus));
    end

    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_fire))
        begin
            if (pending_q.size() > 0 &&
                !((idle_mode == IDLE_SEND && $urandom_range(99) < 51) ||
                  (idle_mode == IDLE_BOTH && $urandom_range(99) < 20)))
            begin
                on_bus = pending_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= on_bus.kind;
                s_tdata <= {4'b0, on_bus.val, on_bus.col, on_bus.row};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // output side: back-pressure, with one long hold-off on request
    always @(negedge clk)
    begin
        if (stall_go && !stall_taken)
        begin
            stall_taken <= 1'b1;
            hold_cnt <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= !((idle_mode == IDLE_RECV && $urandom_range(99) < 51) ||
                          (idle_mode == IDLE_BOTH && $urandom_range(99) < 20));
    end

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (answer_q.size() == 0)
            begin
                $display("%0t: unexpected beat data=%h user=%h", $time, m_tdata, m_tuser);
                mismatches++;
            end
            else
            begin
                answer_t want;
                want = answer_q.pop_front();
                if (m_tdata !== want.data || m_tuser[KIND_W-1:0] !== want.kind ||
                    m_tuser[KIND_W] !== want.err)
                begin
                    $display("%0t: expected data=%h kind=%0d err=%b, got data=%h kind=%0d err=%b",
                             $time, want.data, want.kind, want.err,
                             m_tdata, m_tuser[KIND_W-1:0], m_tuser[KIND_W]);
                    mismatches++;
                end
            end
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [APB_DW-1:0] value);
        int d;
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        d = int'(value[DIM_W-1:0]);
        if (d > MAX_DIM) d = MAX_DIM;
        case (idx)
            REG_ROWS_A:    dim_rows = d;
            REG_INNER_DIM: dim_inner = d;
            default:       dim_cols = d;
        endcase
    endtask

    task automatic set_dims(int r, int k, int c);
        reg_write(REG_ROWS_A, r);
        reg_write(REG_INNER_DIM, k);
        reg_write(REG_COLS_B, c);
    endtask

    task automatic queue_req(logic [KIND_W-1:0] kind, int row, int col, logic [ELEM_W-1:0] val);
        request_t r;
        r.kind = kind;
        r.row = IDX_W'(row);
        r.col = IDX_W'(col);
        r.val = val;
        if (kind == REQ_WRITE_A && row < dim_rows && col < dim_inner)
            a_filled[row*MAX_DIM+col] = 1'b1;
        if (kind == REQ_WRITE_B && row < dim_inner && col < dim_cols)
            b_filled[row*MAX_DIM+col] = 1'b1;
        pending_q.push_back(r);
    endtask

    function automatic bit operands_ready();
        for (int i = 0; i < dim_rows; i++)
            for (int k = 0; k < dim_inner; k++)
                if (!a_filled[i*MAX_DIM+k]) return 1'b0;
        for (int k = 0; k < dim_inner; k++)
            for (int j = 0; j < dim_cols; j++)
                if (!b_filled[k*MAX_DIM+j]) return 1'b0;
        return 1'b1;
    endfunction

    task automatic drain();
        do @(negedge clk);
        while (pending_q.size() > 0 || s_tvalid || answer_q.size() > 0);
        repeat (10) @(negedge clk);
    endtask

    task automatic fill_operands();
        for (int i = 0; i < dim_rows; i++)
            for (int k = 0; k < dim_inner; k++)
                queue_req(REQ_WRITE_A, i, k, $urandom);
        for (int k = 0; k < dim_inner; k++)
            for (int j = 0; j < dim_cols; j++)
                queue_req(REQ_WRITE_B, k, j, $urandom);
    endtask

    task automatic random_body(int n);
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 30 && dim_rows > 0 && dim_cols > 0)
                queue_req(REQ_READ_C, $urandom_range(dim_rows-1), $urandom_range(dim_cols-1), 0);
            else if (pick < 45 && dim_rows > 0 && dim_cols > 0)
                queue_req(REQ_WRITE_C, $urandom_range(dim_rows-1),
                          $urandom_range(dim_cols-1), $urandom);
            else if (pick < 55 && operands_ready())
                queue_req(REQ_COMPUTE, $urandom_range(63), $urandom_range(63), $urandom);
            else if (pick < 65 && dim_rows > 0 && dim_inner > 0)
                queue_req(REQ_WRITE_A, $urandom_range(dim_rows-1),
                          $urandom_range(dim_inner-1), $urandom);
            else if (pick < 72 && dim_inner > 0 && dim_cols > 0)
                queue_req(REQ_WRITE_B, $urandom_range(dim_inner-1),
                          $urandom_range(dim_cols-1), $urandom);
            else if (pick < 77)
                queue_req(KIND_W'(REQ_UNUSED_LO + $urandom_range(2)), $urandom_range(63),
                          $urandom_range(63), $urandom);
            else
                // noise: full index range, mostly out of bounds
                queue_req(KIND_W'(REQ_WRITE_A + $urandom_range(2) + 2*$urandom_range(1)),
                          $urandom_range(63), $urandom_range(63), $urandom);
        end
    endtask

    initial
    begin
        int r;
        int k;
        int c;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: default 64x64x64 dims, corners, unknown kinds
        queue_req(REQ_READ_C, 0, 0, 0);
        queue_req(REQ_READ_C, 63, 63, 0);
        queue_req(REQ_WRITE_C, 63, 63, 32'h8000_0000);
        queue_req(REQ_WRITE_C, 0, 0, 32'h7fff_ffff);
        queue_req(REQ_READ_C, 63, 63, 0);
        queue_req(REQ_READ_C, 0, 0, 32'hffff_ffff);
        queue_req(REQ_WRITE_A, 63, 0, 32'hffff_ffff);
        queue_req(REQ_WRITE_B, 0, 63, 32'h0000_0001);
        for (int u = 0; u < 3; u++)
            queue_req(KIND_W'(REQ_UNUSED_LO + u), 63, 63, 32'hffff_ffff);
        drain();

        // empty dimension: writes and reads flagged, compute is a no-op
        set_dims(0, 5, 5);
        queue_req(REQ_WRITE_A, 0, 0, 1);
        queue_req(REQ_WRITE_C, 0, 0, 1);
        queue_req(REQ_READ_C, 0, 0, 0);
        queue_req(REQ_COMPUTE, 0, 0, 0);
        drain();

        // oversize value saturates; tall-thin and short-wide extremes
        set_dims(127, 1, 127);
        fill_operands();
        queue_req(REQ_WRITE_C, 63, 63, 32'hffff_ffff);
        queue_req(REQ_COMPUTE, 0, 0, 0);
        queue_req(REQ_READ_C, 63, 63, 0);
        queue_req(REQ_READ_C, 32, 17, 0);
        queue_req(REQ_WRITE_B, 1, 0, 5);
        drain();
        set_dims(1, 64, 1);
        fill_operands();
        queue_req(REQ_COMPUTE, 0, 0, 0);
        queue_req(REQ_READ_C, 0, 0, 0);
        queue_req(REQ_READ_C, 1, 0, 0);
        drain();

        for (int ph = 0; ph < 12; ph++)
        begin
            idle_mode = idle_mode_t'(ph % 4);
            r = $urandom_range(1, 8);
            k = $urandom_range(1, 8);
            c = $urandom_range(1, 8);
            if (ph == 5) k = 0;
            if (ph == 9) r = 1;
            set_dims(r, k, c);
            fill_operands();
            if (ph == 2) stall_go = 1'b1;
            random_body(35);
            drain();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/core/bimm_pkg.sv
rtl/core/bimm_ram.sv
rtl/core/bimm_mac.sv
rtl/core/blocked_int_matrix_multiply_core.sv
tb/blocked_int_matrix_multiply_core_test.sv
